/* design/tcs_pkg.sv */
// shared types, register codes and segment encoding for the temperature display unit
`timescale 1ns / 1ps
package tcs_pkg;

  typedef enum logic [1:0] {
    REG_CAL_T1 = 2'd0,
    REG_CAL_T2 = 2'd1,
    REG_CAL_T3 = 2'd2
  } tcs_reg_t;

  localparam int unsigned DISPLAY_MAX = 9999;

  // word handed from the compensation pipe to the display pipe
  typedef struct packed {
    logic               valid;
    logic signed [31:0] fine;
    logic signed [26:0] hund;
  } tcs_comp_t;

  function automatic logic [7:0] seg_encode(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'h7E;
      4'd1:    seg = 8'h0C;
      4'd2:    seg = 8'hB6;
      4'd3:    seg = 8'h9E;
      4'd4:    seg = 8'hCC;
      4'd5:    seg = 8'hDA;
      4'd6:    seg = 8'hFA;
      4'd7:    seg = 8'h0E;
      4'd8:    seg = 8'hFE;
      4'd9:    seg = 8'hDE;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

/* design/temp_compensate_to_segments_unit.sv */
// top level: calibration registers, compensation pipe and display pipe
`timescale 1ns / 1ps
// Takes one raw temperature reading in every clock cycle; busy is always low. Each
// word passes the eight register stages of the pipe and comes out marked by
// out_valid for one cycle, in input order, and cannot be held off. The stages are
// an offset stage, two multiplier stages and a sum stage for the compensation,
// one for the scale to hundredths, and three for range check, decimal digits and
// segment patterns. Write the calibration registers only while no reading is in
// flight.
module temp_compensate_to_segments_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [19:0]         in_raw_reading,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  output logic                out_valid,
  output logic signed [31:0]  out_fine_temp,
  output logic signed [26:0]  out_temp_hundredths,
  output logic                out_out_of_range,
  output logic [7:0]          out_seg_tens,
  output logic [7:0]          out_seg_ones,
  output logic [7:0]          out_seg_tenths,
  output logic [7:0]          out_seg_hundredths
);
  import tcs_pkg::*;

  logic [15:0]        cal_t1_r;
  logic signed [15:0] cal_t2_r, cal_t3_r;
  logic               accept;
  tcs_comp_t          comp;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_t1_r <= '0;
      cal_t2_r <= '0;
      cal_t3_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAL_T1: cal_t1_r <= cfg_wdata;
        REG_CAL_T2: cal_t2_r <= cfg_wdata;
        REG_CAL_T3: cal_t3_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tcs_comp u_comp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .raw      (in_raw_reading),
    .cal_t1   (cal_t1_r),
    .cal_t2   (cal_t2_r),
    .cal_t3   (cal_t3_r),
    .comp_o   (comp)
  );

  tcs_disp u_disp (
    .clk          (clk),
    .rst_n        (rst_n),
    .comp_i       (comp),
    .valid_o      (out_valid),
    .fine_o       (out_fine_temp),
    .hund_o       (out_temp_hundredths),
    .oor_o        (out_out_of_range),
    .seg_tens_o   (out_seg_tens),
    .seg_ones_o   (out_seg_ones),
    .seg_tenths_o (out_seg_tenths),
    .seg_hund_o   (out_seg_hundredths)
  );

  // every accepted reading yields a word
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##8 out_valid)
    else $error("accepted reading produced no word");

  // no word without an earlier accepted reading
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 8))
    else $error("word without a reading");

  // out of range blanks every digit
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |->
      (out_seg_tens == 8'h00 && out_seg_ones == 8'h00 &&
       out_seg_tenths == 8'h00 && out_seg_hundredths == 8'h00))
    else $error("digits shown while out of range");

  // the flag agrees with the reported hundredths
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_out_of_range ==
      (out_temp_hundredths < 0 || out_temp_hundredths > 27'sd9999)))
    else $error("range flag disagrees with hundredths");

endmodule

/* design/tcs_comp.sv */
// compensation pipeline: raw reading to fine temperature and hundredths of a degree
`timescale 1ns / 1ps
module tcs_comp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [19:0]          raw,
  input  logic [15:0]          cal_t1,
  input  logic signed [15:0]   cal_t2,
  input  logic signed [15:0]   cal_t3,
  output tcs_pkg::tcs_comp_t   comp_o
);
  import tcs_pkg::*;

  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [17:0] a_r, a_nxt;
  logic signed [16:0] d_r, d_nxt;
  logic signed [33:0] p1_r, p1_nxt;
  logic signed [33:0] sq_full;
  logic [31:0]        sq_r;
  logic signed [22:0] var1_r, var1_nxt;
  logic signed [35:0] p2_r, p2_nxt;
  logic signed [21:0] var2;
  logic signed [23:0] fine_r, fine_nxt;
  logic signed [26:0] fine_ext, x5, x5_bias;
  logic signed [26:0] hund_r, hund_nxt;
  logic signed [31:0] fine32_r;

  // stage 1: offsets against the first calibration word
  assign a_nxt = signed'({1'b0, raw[19:3]}) - signed'({1'b0, cal_t1, 1'b0});
  assign d_nxt = signed'({1'b0, raw[19:4]}) - signed'({1'b0, cal_t1});

  // stage 2: linear product and square
  assign p1_nxt  = 34'(a_r) * 34'(cal_t2);
  assign sq_full = 34'(d_r) * 34'(d_r);

  // stage 3: linear term done, quadratic product
  assign var1_nxt = p1_r[33:11];
  assign p2_nxt   = 36'(signed'({1'b0, sq_r[31:12]})) * 36'(cal_t3);

  // stage 4: sum of both terms
  assign var2     = p2_r[35:14];
  assign fine_nxt = {var1_r[22], var1_r} + {{2{var2[21]}}, var2};

  // stage 5: times 5 over 256, truncated toward zero
  assign fine_ext = {{3{fine_r[23]}}, fine_r};
  assign x5       = (fine_ext <<< 2) + fine_ext;
  assign x5_bias  = x5 + 27'sd255;
  assign hund_nxt = x5[26] ? (x5_bias >>> 8) : (x5 >>> 8);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    d_r      <= d_nxt;
    p1_r     <= p1_nxt;
    sq_r     <= sq_full[31:0];
    var1_r   <= var1_nxt;
    p2_r     <= p2_nxt;
    fine_r   <= fine_nxt;
    hund_r   <= hund_nxt;
    fine32_r <= {{8{fine_r[23]}}, fine_r};
  end

  assign comp_o.valid = v5_r;
  assign comp_o.fine  = fine32_r;
  assign comp_o.hund  = hund_r;

endmodule

/* design/tcs_disp.sv */
// display pipeline: range check, decimal digits and segment patterns
`timescale 1ns / 1ps
module tcs_disp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcs_pkg::tcs_comp_t   comp_i,
  output logic                 valid_o,
  output logic signed [31:0]   fine_o,
  output logic signed [26:0]   hund_o,
  output logic                 oor_o,
  output logic [7:0]           seg_tens_o,
  output logic [7:0]           seg_ones_o,
  output logic [7:0]           seg_tenths_o,
  output logic [7:0]           seg_hund_o
);
  import tcs_pkg::*;

  logic               v6_r, v7_r, v8_r;
  logic signed [31:0] fine6_r, fine7_r, fine8_r;
  logic signed [26:0] hund6_r, hund7_r, hund8_r;
  logic               oor_nxt, oor6_r, oor7_r, oor8_r;
  logic [13:0]        h;
  logic [13:0]        h6_r;
  logic [27:0]        m3, m2, m1;
  logic [3:0]         q3_r;
  logic [6:0]         q2_r;
  logic [9:0]         q1_r;
  logic [6:0]         d2_w;
  logic [9:0]         d1_w;
  logic [13:0]        d0_w;
  logic [3:0]         dig3_r, dig2_r, dig1_r, dig0_r;
  logic [7:0]         seg3_r, seg2_r, seg1_r, seg0_r;

  assign h       = comp_i.hund[13:0];
  assign oor_nxt = comp_i.hund[26] || (comp_i.hund > 27'(DISPLAY_MAX));

  // stage 6: quotients by 1000, 100 and 10 through reciprocal multiplies
  assign m3 = {14'd0, h} * 28'd8389;
  assign m2 = {14'd0, h} * 28'd5243;
  assign m1 = {14'd0, h} * 28'd6554;

  // stage 7: digits from neighboring quotients
  assign d2_w = q2_r - 7'({3'd0, q3_r} * 7'd10);
  assign d1_w = q1_r - 10'({3'd0, q2_r} * 10'd10);
  assign d0_w = h6_r - 14'({4'd0, q1_r} * 14'd10);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      v6_r <= comp_i.valid;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    fine6_r <= comp_i.fine;
    hund6_r <= comp_i.hund;
    oor6_r  <= oor_nxt;
    h6_r    <= h;
    q3_r    <= m3[26:23];
    q2_r    <= m2[25:19];
    q1_r    <= m1[25:16];

    fine7_r <= fine6_r;
    hund7_r <= hund6_r;
    oor7_r  <= oor6_r;
    dig3_r  <= q3_r;
    dig2_r  <= d2_w[3:0];
    dig1_r  <= d1_w[3:0];
    dig0_r  <= d0_w[3:0];

    // stage 8: segment patterns, with all digits blanked when out of range
    fine8_r <= fine7_r;
    hund8_r <= hund7_r;
    oor8_r  <= oor7_r;
    seg3_r  <= oor7_r ? 8'h00 : seg_encode(dig3_r);
    seg2_r  <= oor7_r ? 8'h00 : seg_encode(dig2_r);
    seg1_r  <= oor7_r ? 8'h00 : seg_encode(dig1_r);
    seg0_r  <= oor7_r ? 8'h00 : seg_encode(dig0_r);
  end

  assign valid_o      = v8_r;
  assign fine_o       = fine8_r;
  assign hund_o       = hund8_r;
  assign oor_o        = oor8_r;
  assign seg_tens_o   = seg3_r;
  assign seg_ones_o   = seg2_r;
  assign seg_tenths_o = seg1_r;
  assign seg_hund_o   = seg0_r;

endmodule
